// File: src/spv_pkg.sv
package spv_pkg;

    localparam int DEF_MAX_SCHEME_BYTES = 256;
    localparam int DEF_MAX_PATH_BYTES   = 4096;

    localparam int SCHEME_W = 9;
    localparam int REL_W    = 13;
    localparam int SEG_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [SCHEME_W-1:0] SCHEME_CAP_RST = 9'd32;
    localparam logic [REL_W-1:0]    REL_CAP_RST    = 13'd256;

    localparam logic [CFG_IDX_W-1:0] REG_SCHEME_CAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REL_CAP    = 2'd1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    localparam logic [SEG_W-1:0] SEG_MAX = 2'd3;

    typedef enum logic [1:0] {
        ROLE_SCHEME = 2'd0,
        ROLE_SEP    = 2'd1,
        ROLE_REL    = 2'd2
    } role_t;

    typedef enum logic [1:0] {
        PH_SCHEME   = 2'd0,
        PH_COLON    = 2'd1,
        PH_SLASH    = 2'd2,
        PH_RELATIVE = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic [SCHEME_W-1:0] scheme_count;
        logic [REL_W-1:0]    relative_count;
        logic [SEG_W-1:0]    segment_count;
        logic                segment_all_dots;
        logic                failed;
    } path_state_t;

    localparam path_state_t STATE_CLEAR = '{
        phase:            PH_SCHEME,
        scheme_count:     '0,
        relative_count:   '0,
        segment_count:    '0,
        segment_all_dots: 1'b1,
        failed:           1'b0
    };

    typedef struct packed {
        logic [7:0]          echo_byte;
        role_t               role;
        logic                final_flag;
        logic                path_valid;
        logic [SCHEME_W-1:0] scheme_length;
        logic [REL_W-1:0]    relative_length;
    } result_t;

    function automatic logic is_scheme_char(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER || c == CH_DASH;
    endfunction

endpackage

// File: src/spv_step.sv
module spv_step
    import spv_pkg::*;
#(
    parameter int MAX_SCHEME_BYTES = DEF_MAX_SCHEME_BYTES,
    parameter int MAX_PATH_BYTES   = DEF_MAX_PATH_BYTES
)
(
    input  path_state_t         cur,
    input  logic [7:0]          path_byte,
    input  logic                path_end,
    input  logic [SCHEME_W-1:0] scheme_cap,
    input  logic [REL_W-1:0]    rel_cap,
    output path_state_t         nxt,
    output result_t             res
);

    localparam logic [SCHEME_W:0] SCH_TOP = (SCHEME_W+1)'(MAX_SCHEME_BYTES);
    localparam logic [REL_W:0]    REL_TOP = (REL_W+1)'(MAX_PATH_BYTES);

    path_state_t         s;
    logic                done;
    logic [SCHEME_W:0]   sch_sum;
    logic [SCHEME_W-1:0] sch;
    logic [REL_W:0]      rel_sum;
    logic                valid;

    always_comb
    begin
        s        = cur;
        done     = 1'b0;
        res.role = ROLE_SCHEME;
        sch      = cur.scheme_count;
        valid    = 1'b0;
        sch_sum  = '0;
        rel_sum  = '0;

        if (path_byte == CH_NUL)
            s.failed = 1'b1;

        if (cur.phase == PH_COLON || cur.phase == PH_SLASH)
        begin
            if (path_byte == CH_SLASH)
            begin
                res.role = ROLE_SEP;
                s.phase  = (cur.phase == PH_COLON) ? PH_SLASH : PH_RELATIVE;
                done     = 1'b1;
            end
            else
            begin
                s.failed = 1'b1;
                sch_sum  = {1'b0, sch} + ((cur.phase == PH_COLON) ? 10'd1 : 10'd2);
                sch      = (sch_sum > SCH_TOP) ? SCH_TOP[SCHEME_W-1:0]
                                               : sch_sum[SCHEME_W-1:0];
                s.phase  = PH_SCHEME;
            end
        end

        if (!done)
        begin
            if (s.phase == PH_RELATIVE)
            begin
                res.role = ROLE_REL;
                rel_sum  = {1'b0, s.relative_count} + 14'd1;
                s.relative_count = (rel_sum > REL_TOP) ? REL_TOP[REL_W-1:0]
                                                       : rel_sum[REL_W-1:0];
                if (path_byte == CH_BSL || path_byte == CH_COLON)
                    s.failed = 1'b1;
                if (path_byte == CH_SLASH)
                begin
                    if (s.segment_count == '0 ||
                        (s.segment_all_dots && s.segment_count <= 2'd2))
                        s.failed = 1'b1;
                    s.segment_count    = '0;
                    s.segment_all_dots = 1'b1;
                end
                else
                begin
                    if (s.segment_count != SEG_MAX)
                        s.segment_count = s.segment_count + 2'd1;
                    if (path_byte != CH_DOT)
                        s.segment_all_dots = 1'b0;
                end
            end
            else if (path_byte == CH_COLON)
            begin
                res.role = ROLE_SEP;
                s.phase  = PH_COLON;
            end
            else
            begin
                if (!is_scheme_char(path_byte))
                    s.failed = 1'b1;
                sch_sum = {1'b0, sch} + 10'd1;
                sch     = (sch_sum > SCH_TOP) ? SCH_TOP[SCHEME_W-1:0]
                                              : sch_sum[SCHEME_W-1:0];
            end
        end
        s.scheme_count = sch;

        if (path_end)
        begin
            if (s.phase == PH_RELATIVE)
            begin
                if (s.segment_count == '0 ||
                    (s.segment_all_dots && s.segment_count <= 2'd2))
                    s.failed = 1'b1;
            end
            else
                s.failed = 1'b1;
            valid = !s.failed &&
                    s.scheme_count != '0 &&
                    s.scheme_count < scheme_cap &&
                    {1'b0, s.scheme_count} < SCH_TOP &&
                    s.relative_count != '0 &&
                    s.relative_count < rel_cap &&
                    {1'b0, s.relative_count} < REL_TOP;
        end

        res.echo_byte       = path_byte;
        res.final_flag      = path_end;
        res.path_valid      = valid;
        res.scheme_length   = s.scheme_count;
        res.relative_length = s.relative_count;
        nxt                 = path_end ? STATE_CLEAR : s;
    end

endmodule

// File: src/scheme_path_validator.sv
// Channel  Direction  Signals                                 Word
// s_axis   in         tvalid tready tdata[7:0] tlast          one path byte, tlast = path end
// m_axis   out        tvalid tready tdata[31:0] tuser tlast   one tagged echo, tlast = final
// cfg      in         valid ready index[1:0] data[12:0]       capacity register write
//
// One word in, one word out; a word may be taken every cycle.
// The result is registered: the parse state and the result register load on the same edge.
// The result register holds under back-pressure; s_axis_tready drops only while it
// holds a word that m_axis is not taking this cycle.
// Reset clears the parse state and the result valid; capacities return to 32 and 256.
// cfg is always ready and takes effect on the next word.
module scheme_path_validator
    import spv_pkg::*;
#(
    parameter int MAX_SCHEME_BYTES = DEF_MAX_SCHEME_BYTES,
    parameter int MAX_PATH_BYTES   = DEF_MAX_PATH_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,  // [7:0] path_byte
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,  // [7:0] echo_byte, [8] path_valid,
                                                 // [17:9] scheme_length,
                                                 // [30:18] relative_length, [31] zero
    output logic [1:0]            m_axis_tuser,  // [1:0] role
    output logic                  m_axis_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    path_state_t         state_reg, state_next;
    result_t             res_reg, res_next;
    logic                out_valid_reg;
    logic [SCHEME_W-1:0] scheme_cap_reg;
    logic [REL_W-1:0]    rel_cap_reg;
    logic                s_fire;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    spv_step #(
        .MAX_SCHEME_BYTES (MAX_SCHEME_BYTES),
        .MAX_PATH_BYTES   (MAX_PATH_BYTES)
    ) u_step (
        .cur        (state_reg),
        .path_byte  (s_axis_tdata),
        .path_end   (s_axis_tlast),
        .scheme_cap (scheme_cap_reg),
        .rel_cap    (rel_cap_reg),
        .nxt        (state_next),
        .res        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scheme_cap_reg <= SCHEME_CAP_RST;
            rel_cap_reg    <= REL_CAP_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SCHEME_CAP: scheme_cap_reg <= cfg_data[SCHEME_W-1:0];
                REG_REL_CAP:    rel_cap_reg    <= cfg_data[REL_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
                state_reg <= state_next;
            if (s_fire)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
            res_reg <= res_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = res_reg.final_flag;
    assign m_axis_tuser  = res_reg.role;
    assign m_axis_tdata  = {1'b0, res_reg.relative_length, res_reg.scheme_length,
                            res_reg.path_valid, res_reg.echo_byte};

    a_word_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> m_axis_tvalid)
        else $error("accepted word produced no result");

    a_role_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("undefined role code");

    a_valid_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[8]) |-> m_axis_tlast)
        else $error("verdict on a non-final word");

    a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && s_axis_tlast) |=>
            (state_reg.scheme_count == '0 && state_reg.relative_count == '0 &&
             !state_reg.failed))
        else $error("path state not cleared after final word");

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb
    import spv_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam int N_PHASES    = 8;
    localparam int PHASE_WORDS = 70;
    localparam int STALL_LIMIT = 3000;

    localparam logic [CFG_DATA_W-1:0] SCHEME_CAPS [N_PHASES] =
        '{13'd32, 13'd1, 13'd8, 13'd0, 13'h1FFF, 13'd0, 13'd4, 13'd256};
    localparam logic [CFG_DATA_W-1:0] REL_CAPS [N_PHASES] =
        '{13'd256, 13'd1, 13'd20, 13'd0, 13'h1FFF, 13'd0, 13'd6, 13'd4096};

    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_SCHEME,
        FLAW_NUL,
        FLAW_BROKEN_SEP,
        FLAW_NO_SEP,
        FLAW_END_AT_SEP,
        FLAW_EMPTY_SCHEME,
        FLAW_EMPTY_REL,
        FLAW_BSL,
        FLAW_COLON,
        FLAW_EMPTY_SEG,
        FLAW_DOT_SEG,
        FLAW_NOISE
    } flaw_t;

    typedef struct {
        logic [7:0] b;
        logic       l;
        logic       pin;
        result_t    want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic    pin_on = 1'b0;
    result_t pin_res = '0;

    int snd_idle = 14;
    int rcv_idle = 75;
    int err_count = 0;
    int stall = 0;

    result_t    echo_due [$];
    logic [7:0] path_bytes [$];

    int     cap_scheme = 32;
    int     cap_rel = 256;
    phase_t sp_phase = PH_SCHEME;
    int     sp_scheme = 0;
    int     sp_rel = 0;
    int     sp_seg = 0;
    logic   sp_dots = 1'b1;
    logic   sp_bad = 1'b0;

    dir_row_t dir_rows [25] = '{
        '{"a", 1'b0, 1'b1, '{"a", ROLE_SCHEME, 1'b0, 1'b0, 9'd1, 13'd0}},
        '{CH_COLON, 1'b0, 1'b1, '{CH_COLON, ROLE_SEP, 1'b0, 1'b0, 9'd1, 13'd0}},
        '{CH_SLASH, 1'b0, 1'b1, '{CH_SLASH, ROLE_SEP, 1'b0, 1'b0, 9'd1, 13'd0}},
        '{CH_SLASH, 1'b0, 1'b1, '{CH_SLASH, ROLE_SEP, 1'b0, 1'b0, 9'd1, 13'd0}},
        '{"b", 1'b1, 1'b1, '{"b", ROLE_REL, 1'b1, 1'b1, 9'd1, 13'd1}},
        '{CH_NUL, 1'b1, 1'b1, '{CH_NUL, ROLE_SCHEME, 1'b1, 1'b0, 9'd1, 13'd0}},
        '{8'hFF, 1'b1, 1'b1, '{8'hFF, ROLE_SCHEME, 1'b1, 1'b0, 9'd1, 13'd0}},
        '{"x", 1'b0, 1'b0, '0},
        '{CH_COLON, 1'b0, 1'b0, '0},
        '{"q", 1'b0, 1'b0, '0},
        '{CH_COLON, 1'b0, 1'b0, '0},
        '{CH_SLASH, 1'b0, 1'b0, '0},
        '{CH_SLASH, 1'b0, 1'b0, '0},
        '{CH_DOT, 1'b1, 1'b0, '0},
        '{CH_COLON, 1'b0, 1'b0, '0},
        '{CH_SLASH, 1'b0, 1'b0, '0},
        '{"z", 1'b1, 1'b0, '0},
        '{"9", 1'b0, 1'b0, '0},
        '{CH_COLON, 1'b0, 1'b0, '0},
        '{CH_SLASH, 1'b0, 1'b0, '0},
        '{CH_SLASH, 1'b0, 1'b0, '0},
        '{CH_DOT, 1'b0, 1'b0, '0},
        '{CH_DOT, 1'b0, 1'b0, '0},
        '{CH_SLASH, 1'b0, 1'b0, '0},
        '{CH_BSL, 1'b1, 1'b0, '0}
    };

    scheme_path_validator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int sat_add(input int v, input int n, input int top);
        return (v + n > top) ? top : v + n;
    endfunction

    function automatic logic is_name_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               (c >= "0" && c <= "9") || c == CH_UNDER || c == CH_DASH;
    endfunction

    function automatic void close_seg();
        if (sp_seg == 0 || (sp_dots && sp_seg <= 2))
            sp_bad = 1'b1;
        sp_seg = 0;
        sp_dots = 1'b1;
    endfunction

    function automatic result_t scan_byte(input logic [7:0] c, input logic last);
        result_t r;
        logic    sep_done;
        r = '0;
        sep_done = 1'b0;
        r.role = ROLE_SCHEME;
        if (c == CH_NUL)
            sp_bad = 1'b1;
        if (sp_phase == PH_COLON || sp_phase == PH_SLASH)
        begin
            if (c == CH_SLASH)
            begin
                r.role = ROLE_SEP;
                sp_phase = (sp_phase == PH_COLON) ? PH_SLASH : PH_RELATIVE;
                sep_done = 1'b1;
            end
            else
            begin
                sp_bad = 1'b1;
                sp_scheme = sat_add(sp_scheme, (sp_phase == PH_COLON) ? 1 : 2,
                                    DEF_MAX_SCHEME_BYTES);
                sp_phase = PH_SCHEME;
            end
        end
        if (!sep_done)
        begin
            if (sp_phase == PH_RELATIVE)
            begin
                r.role = ROLE_REL;
                sp_rel = sat_add(sp_rel, 1, DEF_MAX_PATH_BYTES);
                if (c == CH_BSL || c == CH_COLON)
                    sp_bad = 1'b1;
                if (c == CH_SLASH)
                    close_seg();
                else
                begin
                    sp_seg = sat_add(sp_seg, 1, 3);
                    if (c != CH_DOT)
                        sp_dots = 1'b0;
                end
            end
            else if (c == CH_COLON)
            begin
                r.role = ROLE_SEP;
                sp_phase = PH_COLON;
            end
            else
            begin
                if (!is_name_char(c))
                    sp_bad = 1'b1;
                sp_scheme = sat_add(sp_scheme, 1, DEF_MAX_SCHEME_BYTES);
            end
        end
        r.echo_byte = c;
        r.final_flag = last;
        r.scheme_length = sp_scheme[SCHEME_W-1:0];
        r.relative_length = sp_rel[REL_W-1:0];
        if (last)
        begin
            if (sp_phase == PH_RELATIVE)
                close_seg();
            else
                sp_bad = 1'b1;
            r.path_valid = !sp_bad && sp_scheme > 0 && sp_scheme < cap_scheme &&
                           sp_scheme < DEF_MAX_SCHEME_BYTES && sp_rel > 0 &&
                           sp_rel < cap_rel && sp_rel < DEF_MAX_PATH_BYTES;
            sp_phase = PH_SCHEME;
            sp_scheme = 0;
            sp_rel = 0;
            sp_seg = 0;
            sp_dots = 1'b1;
            sp_bad = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [7:0] name_char();
        case ($urandom_range(0, 4))
            0: return 8'(8'h41 + $urandom_range(0, 25));
            1: return 8'(8'h30 + $urandom_range(0, 9));
            2: return $urandom_range(0, 1) ? CH_UNDER : CH_DASH;
            default: return 8'(8'h61 + $urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] rel_char();
        case ($urandom_range(0, 9))
            6: return 8'(8'h30 + $urandom_range(0, 9));
            7: return CH_DOT;
            8: return CH_DASH;
            9: return 8'(8'h41 + $urandom_range(0, 25));
            default: return 8'(8'h61 + $urandom_range(0, 25));
        endcase
    endfunction

    function automatic void make_path();
        flaw_t fl;
        int    ns;
        int    nseg;
        int    nc;
        int    rel_start;
        int    s;
        path_bytes.delete();
        fl = ($urandom_range(0, 99) < 65) ? FLAW_NONE
                                          : flaw_t'($urandom_range(1, FLAW_NOISE));
        ns = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        if (fl == FLAW_EMPTY_SCHEME)
            ns = 0;
        repeat (ns) path_bytes.push_back(name_char());
        if (fl == FLAW_BAD_SCHEME)
            path_bytes[$urandom_range(0, ns - 1)] = 8'($urandom_range(0, 255));
        if (fl == FLAW_BROKEN_SEP)
        begin
            path_bytes.push_back(CH_COLON);
            if ($urandom_range(0, 1))
                path_bytes.push_back(CH_SLASH);
            path_bytes.push_back(name_char());
        end
        if (fl == FLAW_END_AT_SEP)
        begin
            path_bytes.push_back(CH_COLON);
            repeat ($urandom_range(0, 2)) path_bytes.push_back(CH_SLASH);
            return;
        end
        if (fl != FLAW_NO_SEP)
        begin
            path_bytes.push_back(CH_COLON);
            path_bytes.push_back(CH_SLASH);
            path_bytes.push_back(CH_SLASH);
        end
        rel_start = path_bytes.size();
        if (fl != FLAW_EMPTY_REL)
        begin
            nseg = $urandom_range(1, 4);
            for (s = 0; s < nseg; s++)
            begin
                if (s > 0)
                    path_bytes.push_back(CH_SLASH);
                if ($urandom_range(0, 19) == 0)
                    repeat (3) path_bytes.push_back(CH_DOT);
                else
                begin
                    nc = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(1, 5);
                    repeat (nc) path_bytes.push_back(rel_char());
                end
            end
        end
        case (fl)
            FLAW_BSL:
                path_bytes.insert($urandom_range(rel_start, path_bytes.size()), CH_BSL);
            FLAW_COLON:
                path_bytes.insert($urandom_range(rel_start, path_bytes.size()), CH_COLON);
            FLAW_EMPTY_SEG:
                path_bytes.insert($urandom_range(0, 1) ? rel_start : path_bytes.size(),
                                  CH_SLASH);
            FLAW_DOT_SEG:
            begin
                path_bytes.push_back(CH_SLASH);
                path_bytes.push_back(CH_DOT);
                if ($urandom_range(0, 1))
                    path_bytes.push_back(CH_DOT);
            end
            FLAW_NUL:
                path_bytes[$urandom_range(0, path_bytes.size() - 1)] = CH_NUL;
            FLAW_NOISE:
                path_bytes[$urandom_range(0, path_bytes.size() - 1)] =
                    8'($urandom_range(0, 255));
            default: ;
        endcase
        if (path_bytes.size() == 0)
            path_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void make_long(input int ns, input int nr);
        path_bytes.delete();
        repeat (ns) path_bytes.push_back(name_char());
        path_bytes.push_back(CH_COLON);
        path_bytes.push_back(CH_SLASH);
        path_bytes.push_back(CH_SLASH);
        repeat (nr) path_bytes.push_back(8'(8'h61 + $urandom_range(0, 25)));
    endfunction

    task automatic send_word(input logic [7:0] b, input logic l, input logic pin,
                             input result_t want);
        while ($urandom_range(0, 99) < snd_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= l;
        pin_on <= pin;
        pin_res <= want;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_path();
        int i;
        for (i = 0; i < path_bytes.size(); i++)
            send_word(path_bytes[i], i == path_bytes.size() - 1, 1'b0, '0);
    endtask

    task automatic drain_words();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (echo_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic run_phase(input int n_words);
        int sent;
        sent = 0;
        while (sent < n_words)
        begin
            make_path();
            send_path();
            sent += path_bytes.size();
            if ($urandom_range(0, 14) == 0)
                drain_words();
        end
    endtask

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle);

    always @(posedge clk)
    begin : monitor
        result_t got;
        result_t want;
        result_t pred;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.echo_byte = m_axis_tdata[7:0];
                got.path_valid = m_axis_tdata[8];
                got.scheme_length = m_axis_tdata[17:9];
                got.relative_length = m_axis_tdata[30:18];
                got.role = role_t'(m_axis_tuser);
                got.final_flag = m_axis_tlast;
                if (echo_due.size() == 0)
                begin
                    $error("result word with nothing expected");
                    err_count++;
                end
                else
                begin
                    want = echo_due.pop_front();
                    if (got.echo_byte !== want.echo_byte)
                    begin
                        $error("echo_byte: expected %0d, actual %0d",
                               want.echo_byte, got.echo_byte);
                        err_count++;
                    end
                    if (got.role !== want.role)
                    begin
                        $error("role: expected %0d, actual %0d", want.role, got.role);
                        err_count++;
                    end
                    if (got.final_flag !== want.final_flag)
                    begin
                        $error("final_flag: expected %0d, actual %0d",
                               want.final_flag, got.final_flag);
                        err_count++;
                    end
                    if (got.path_valid !== want.path_valid)
                    begin
                        $error("path_valid: expected %0d, actual %0d",
                               want.path_valid, got.path_valid);
                        err_count++;
                    end
                    if (got.scheme_length !== want.scheme_length)
                    begin
                        $error("scheme_length: expected %0d, actual %0d",
                               want.scheme_length, got.scheme_length);
                        err_count++;
                    end
                    if (got.relative_length !== want.relative_length)
                    begin
                        $error("relative_length: expected %0d, actual %0d",
                               want.relative_length, got.relative_length);
                        err_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                pred = scan_byte(s_axis_tdata, s_axis_tlast);
                echo_due.push_back(pin_on ? pin_res : pred);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_SCHEME_CAP)
                    cap_scheme = int'(cfg_data[SCHEME_W-1:0]);
                else if (cfg_index == REG_REL_CAP)
                    cap_rel = int'(cfg_data[REL_W-1:0]);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                stall = 0;
            else
                stall++;
            if (stall >= STALL_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        int ph;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_word(dir_rows[i].b, dir_rows[i].l, dir_rows[i].pin, dir_rows[i].want);

        for (ph = 0; ph < N_PHASES; ph++)
        begin
            drain_words();
            snd_idle = (ph < 3) ? 14 : (ph < 6) ? 75 : 0;
            rcv_idle = (ph < 3) ? 75 : (ph < 6) ? 14 : 0;
            cfg_write(REG_SCHEME_CAP, (ph == 5) ? 13'($urandom_range(0, 8191))
                                                : SCHEME_CAPS[ph]);
            cfg_write(REG_REL_CAP, (ph == 5) ? 13'($urandom_range(1, 64)) : REL_CAPS[ph]);
            if (ph == 4)
            begin
                cfg_write(REG_SPARE_LO, 13'($urandom_range(0, 8191)));
                cfg_write(REG_SPARE_HI, 13'($urandom_range(0, 8191)));
            end
            cfg_valid <= 1'b0;
            run_phase(PHASE_WORDS);
            if (ph == N_PHASES - 1)
            begin
                make_long(DEF_MAX_SCHEME_BYTES - 1, 4);
                send_path();
                make_long(DEF_MAX_SCHEME_BYTES + 1, 4);
                send_path();
            end
        end

        drain_words();
        repeat (3) @(posedge clk);
        if (echo_due.size() != 0)
        begin
            $error("expected words left over: %0d", echo_due.size());
            err_count++;
        end
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
src/spv_pkg.sv
src/spv_step.sv
src/scheme_path_validator.sv
bench/tb.sv
